// ===== rtl/tcl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants for the two-class lane queue arbiter.
// ----------------------------------------------------------------------------
package tcl_pkg;

	localparam int ROADS_DEF   = 5;
	localparam int DEPTH_DEF   = 64;
	localparam int ROAD_W      = 3;
	localparam int ID_W        = 10;
	localparam int REM_W       = 7;
	localparam int PASS_W      = 4;
	localparam int MAX_PASSES  = 8;
	localparam logic [PASS_W-1:0] PASS_RST = 4'd3;

	typedef enum logic [1:0] {
		EV_ACCEPT = 2'd0,
		EV_REJECT = 2'd1,
		EV_PASSED = 2'd2,
		EV_EMPTY  = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GRANT,
		ST_READ,
		ST_DATA
	} state_t;

	typedef struct packed {
		logic              kind;
		logic [ROAD_W-1:0] road;
		logic [ID_W-1:0]   vehicle_id;
		logic              urgent;
	} cmd_t;

	typedef struct packed {
		event_t            event_res;
		logic [ROAD_W-1:0] granted_road;
		logic [ID_W-1:0]   passed_id;
		logic              passed_urgent;
		logic [REM_W-1:0]  remaining;
		logic              last;
	} res_t;

endpackage

// ===== rtl/tcl_ram.sv =====
// ----------------------------------------------------------------------------
// tcl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcl_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/tcl_fifo.sv =====
// ----------------------------------------------------------------------------
// tcl_fifo
// Two-word queue; decouples the command side and the result side.
// ----------------------------------------------------------------------------
module tcl_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/tcl_back.sv =====
// ----------------------------------------------------------------------------
// tcl_back
// Queue engine: per-road urgent and normal ring buffers in one RAM, grant
// scan and release sequencer.
// ----------------------------------------------------------------------------
module tcl_back #(
	parameter int ROADS = tcl_pkg::ROADS_DEF,
	parameter int DEPTH = tcl_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  tcl_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	input  logic [tcl_pkg::PASS_W-1:0]  passes,
	input  logic                        res_full,
	output logic                        res_push,
	output tcl_pkg::res_t               res
);

	localparam int RW = (ROADS > 1) ? $clog2(ROADS) : 1;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = 1 + RW + PW;
	localparam int KW = $clog2(tcl_pkg::MAX_PASSES + 1);

	tcl_pkg::state_t state_q, state_nx;

	logic [CW-1:0] occ_q   [ROADS];
	logic [CW-1:0] ucnt_q  [ROADS];
	logic [PW-1:0] uhead_q [ROADS];
	logic [PW-1:0] utail_q [ROADS];
	logic [PW-1:0] nhead_q [ROADS];
	logic [PW-1:0] ntail_q [ROADS];

	logic [RW-1:0] g_q;
	logic          cls_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] n_q;

	logic [RW-1:0] arr_road;
	logic          road_bad;
	logic [RW-1:0] sel;
	logic [RW-1:0] g_pick;
	logic [CW-1:0] bmax;
	logic [KW-1:0] n_clamp;
	logic          is_full;
	logic          do_arrive;
	logic          do_release;
	logic          rel_last;
	logic          cls_now;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [tcl_pkg::ID_W-1:0] ram_rdata;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign arr_road = RW'(cmd.road);
	assign road_bad = ({{(RW + 2){1'b0}}, cmd.road} >= (RW + 2 + tcl_pkg::ROAD_W)'(ROADS));
	assign sel      = (state_q == tcl_pkg::ST_IDLE) ? arr_road : g_q;
	assign is_full  = (occ_q[sel] >= CW'(DEPTH));
	assign cls_now  = (ucnt_q[g_q] != '0);

	// grant scan
	always_comb begin
		g_pick  = '0;
		bmax    = occ_q[0];
		for (int i = 1; i < ROADS; i++) begin
			if (occ_q[i] > bmax) begin
				bmax   = occ_q[i];
				g_pick = RW'(i);
			end
		end
		for (int i = ROADS - 1; i >= 0; i--) begin
			if (ucnt_q[i] != '0) begin
				g_pick  = RW'(i);
			end
		end
	end

	always_comb begin
		if (passes == '0) begin
			n_clamp = KW'(1);
		end else if (passes > tcl_pkg::PASS_W'(tcl_pkg::MAX_PASSES)) begin
			n_clamp = KW'(tcl_pkg::MAX_PASSES);
		end else begin
			n_clamp = KW'(passes);
		end
	end

	assign rel_last = ((k_q + KW'(1)) == n_q) || (occ_q[g_q] == CW'(1));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tcl_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.kind) begin
					state_nx = tcl_pkg::ST_GRANT;
				end
			end
			tcl_pkg::ST_GRANT: begin
				if (occ_q[g_q] == '0) begin
					if (!res_full) begin
						state_nx = tcl_pkg::ST_IDLE;
					end
				end else begin
					state_nx = tcl_pkg::ST_READ;
				end
			end
			tcl_pkg::ST_READ: begin
				state_nx = tcl_pkg::ST_DATA;
			end
			tcl_pkg::ST_DATA: begin
				if (!res_full) begin
					state_nx = rel_last ? tcl_pkg::ST_IDLE : tcl_pkg::ST_READ;
				end
			end
			default: begin
				state_nx = tcl_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		do_arrive  = 1'b0;
		do_release = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = {cmd.urgent, arr_road,
			cmd.urgent ? utail_q[arr_road] : ntail_q[arr_road]};
		ram_raddr  = {cls_now, g_q, cls_now ? uhead_q[g_q] : nhead_q[g_q]};
		case (state_q)
			tcl_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind) begin
						cmd_pop = 1'b1;
					end else if (!res_full) begin
						cmd_pop              = 1'b1;
						res_push             = 1'b1;
						res.granted_road     = cmd.road;
						res.last             = 1'b1;
						if (road_bad) begin
							res.event_res = tcl_pkg::EV_REJECT;
						end else if (is_full) begin
							res.event_res = tcl_pkg::EV_REJECT;
							res.remaining = tcl_pkg::REM_W'(occ_q[sel]);
						end else begin
							do_arrive     = 1'b1;
							ram_we        = 1'b1;
							res.event_res = tcl_pkg::EV_ACCEPT;
							res.remaining = tcl_pkg::REM_W'(occ_q[sel] + CW'(1));
						end
					end
				end
			end
			tcl_pkg::ST_GRANT: begin
				if (occ_q[g_q] == '0) begin
					res_push         = !res_full;
					res.event_res    = tcl_pkg::EV_EMPTY;
					res.granted_road = tcl_pkg::ROAD_W'(g_q);
					res.last         = 1'b1;
				end
			end
			tcl_pkg::ST_READ: begin
				ram_re = 1'b1;
			end
			tcl_pkg::ST_DATA: begin
				if (!res_full) begin
					do_release        = 1'b1;
					res_push          = 1'b1;
					res.event_res     = tcl_pkg::EV_PASSED;
					res.granted_road  = tcl_pkg::ROAD_W'(g_q);
					res.passed_id     = ram_rdata;
					res.passed_urgent = cls_q;
					res.remaining     = tcl_pkg::REM_W'(occ_q[g_q] - CW'(1));
					res.last          = rel_last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcl_pkg::ST_IDLE;
			g_q     <= '0;
			cls_q   <= 1'b0;
			k_q     <= '0;
			n_q     <= '0;
			for (int i = 0; i < ROADS; i++) begin
				occ_q[i]   <= '0;
				ucnt_q[i]  <= '0;
				uhead_q[i] <= '0;
				utail_q[i] <= '0;
				nhead_q[i] <= '0;
				ntail_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (state_q == tcl_pkg::ST_IDLE && cmd_valid && cmd.kind) begin
				k_q <= '0;
				n_q <= n_clamp;
			end
			if (state_q == tcl_pkg::ST_GRANT) begin
				// nothing; g_q was loaded on entry
			end
			if (state_q == tcl_pkg::ST_IDLE) begin
				g_q <= g_pick;
			end
			if (state_q == tcl_pkg::ST_READ) begin
				cls_q <= cls_now;
			end
			if (do_arrive) begin
				occ_q[arr_road] <= occ_q[arr_road] + CW'(1);
				if (cmd.urgent) begin
					ucnt_q[arr_road]  <= ucnt_q[arr_road] + CW'(1);
					utail_q[arr_road] <= inc(utail_q[arr_road]);
				end else begin
					ntail_q[arr_road] <= inc(ntail_q[arr_road]);
				end
			end
			if (do_release) begin
				k_q        <= k_q + KW'(1);
				occ_q[g_q] <= occ_q[g_q] - CW'(1);
				if (cls_q) begin
					ucnt_q[g_q]  <= ucnt_q[g_q] - CW'(1);
					uhead_q[g_q] <= inc(uhead_q[g_q]);
				end else begin
					nhead_q[g_q] <= inc(nhead_q[g_q]);
				end
			end
		end
	end

	tcl_ram #(
		.WIDTH (tcl_pkg::ID_W),
		.DEPTH (2 ** AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.vehicle_id),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== rtl/two_class_lane_queue_arbiter_core.sv =====
// ----------------------------------------------------------------------------
// two_class_lane_queue_arbiter_core
// Per-road two-class vehicle queues with urgent-first, longest-queue grant.
//
//  channel  | handshake          | words
//  ---------+--------------------+-----------------------------------------
//  input    | push / full        | kind, road, vehicle_id, urgent
//  result   | empty / pop        | event_res, granted_road, passed_id,
//           |                    | passed_urgent, remaining, last
//  config   | cfg_we             | cfg_data (passes_per_green)
//
// Arrival: handled in the idle state, one result word; waits while the result queue is full.
// Tick: taken in the idle state, then a grant state, then per released vehicle
// a RAM read state and a registered-data state; a full result queue stalls output.
// Reset clears counts and pointers at once; no clearing pass.
// Two-word queues on both sides let input and result stall independently.
// ----------------------------------------------------------------------------
module two_class_lane_queue_arbiter_core #(
	parameter int ROADS = tcl_pkg::ROADS_DEF,
	parameter int DEPTH = tcl_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcl_pkg::PASS_W-1:0]  cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic                        kind,
	input  logic [tcl_pkg::ROAD_W-1:0]  road,
	input  logic [tcl_pkg::ID_W-1:0]    vehicle_id,
	input  logic                        urgent,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  event_res,
	output logic [tcl_pkg::ROAD_W-1:0]  granted_road,
	output logic [tcl_pkg::ID_W-1:0]    passed_id,
	output logic                        passed_urgent,
	output logic [tcl_pkg::REM_W-1:0]   remaining,
	output logic                        last
);

	logic [tcl_pkg::PASS_W-1:0] passes_q;
	tcl_pkg::cmd_t              cmd_in;
	tcl_pkg::cmd_t              cmd;
	logic                       cmd_empty;
	logic                       cmd_pop;
	tcl_pkg::res_t              res;
	tcl_pkg::res_t              res_out;
	logic                       res_push;
	logic                       res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passes_q <= tcl_pkg::PASS_RST;
		end else if (cfg_we) begin
			passes_q <= cfg_data;
		end
	end

	assign cmd_in.kind       = kind;
	assign cmd_in.road       = road;
	assign cmd_in.vehicle_id = vehicle_id;
	assign cmd_in.urgent     = urgent;

	tcl_fifo #(
		.WIDTH ($bits(tcl_pkg::cmd_t))
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

	tcl_back #(
		.ROADS (ROADS),
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.passes    (passes_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	tcl_fifo #(
		.WIDTH ($bits(tcl_pkg::res_t))
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign event_res     = res_out.event_res;
	assign granted_road  = res_out.granted_road;
	assign passed_id     = res_out.passed_id;
	assign passed_urgent = res_out.passed_urgent;
	assign remaining     = res_out.remaining;
	assign last          = res_out.last;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the two-class lane queue arbiter: a directed table of arrivals
// and ticks, a fill burst and random traffic, every result word checked in
// order against a behavioral copy of the per-road queues and the grant rule.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NROADS = tcl_pkg::ROADS_DEF;
	localparam int NDEPTH = tcl_pkg::DEPTH_DEF;
	localparam int LIMIT = 400000;
	localparam logic KIND_ARRIVE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [tcl_pkg::PASS_W-1:0] cfg_data = '0;
	logic push = 0, pop = 0;
	logic kind = 0, urgent = 0;
	logic [tcl_pkg::ROAD_W-1:0] road = '0;
	logic [tcl_pkg::ID_W-1:0] vehicle_id = '0;
	logic full, empty, passed_urgent, last;
	logic [1:0] event_res;
	logic [tcl_pkg::ROAD_W-1:0] granted_road;
	logic [tcl_pkg::ID_W-1:0] passed_id;
	logic [tcl_pkg::REM_W-1:0] remaining;

	two_class_lane_queue_arbiter_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .kind(kind), .road(road),
		.vehicle_id(vehicle_id), .urgent(urgent), .empty(empty), .pop(pop),
		.event_res(event_res), .granted_road(granted_road),
		.passed_id(passed_id), .passed_urgent(passed_urgent),
		.remaining(remaining), .last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// behavioral queues, head at index 0
	logic [tcl_pkg::ID_W:0] lane_q[NROADS][$];
	int urgent_cnt[NROADS];
	int green_passes;
	tcl_pkg::res_t expected_words[$];
	int errors, mismatches;
	int cycles;
	bit quiet_rx;

	function automatic tcl_pkg::res_t mk(tcl_pkg::event_t e, int rd, int id, bit u,
		int rem, bit l);
		tcl_pkg::res_t r;
		r.event_res = e;
		r.granted_road = tcl_pkg::ROAD_W'(rd);
		r.passed_id = tcl_pkg::ID_W'(id);
		r.passed_urgent = u;
		r.remaining = tcl_pkg::REM_W'(rem);
		r.last = l;
		return r;
	endfunction

	task automatic predict_word(tcl_pkg::cmd_t c);
		int g, n, best;
		logic [tcl_pkg::ID_W:0] e;
		g = -1;
		if (c.kind == KIND_ARRIVE) begin
			if (c.road >= NROADS) begin
				expected_words.push_back(mk(tcl_pkg::EV_REJECT, c.road, 0, 0, 0, 1));
			end else if (lane_q[c.road].size() >= NDEPTH) begin
				expected_words.push_back(mk(tcl_pkg::EV_REJECT, c.road, 0, 0,
					lane_q[c.road].size(), 1));
			end else begin
				if (c.urgent) begin
					lane_q[c.road].insert(urgent_cnt[c.road], {1'b1, c.vehicle_id});
					urgent_cnt[c.road]++;
				end else
					lane_q[c.road].push_back({1'b0, c.vehicle_id});
				expected_words.push_back(mk(tcl_pkg::EV_ACCEPT, c.road, 0, 0,
					lane_q[c.road].size(), 1));
			end
			return;
		end
		for (int i = 0; i < NROADS; i++)
			if (g < 0 && urgent_cnt[i] > 0) g = i;
		if (g < 0) begin
			best = -1;
			for (int i = 0; i < NROADS; i++)
				if (lane_q[i].size() > best) begin
					best = lane_q[i].size();
					g = i;
				end
		end
		n = green_passes == 0 ? 1 : (green_passes > tcl_pkg::MAX_PASSES ?
			tcl_pkg::MAX_PASSES : green_passes);
		if (lane_q[g].size() == 0) begin
			expected_words.push_back(mk(tcl_pkg::EV_EMPTY, g, 0, 0, 0, 1));
			return;
		end
		for (int k = 0; k < n && lane_q[g].size() > 0; k++) begin
			e = lane_q[g].pop_front();
			if (e[tcl_pkg::ID_W] && urgent_cnt[g] > 0) urgent_cnt[g]--;
			expected_words.push_back(mk(tcl_pkg::EV_PASSED, g, e[tcl_pkg::ID_W-1:0],
				e[tcl_pkg::ID_W], lane_q[g].size(), k == n - 1 || lane_q[g].size() == 0));
		end
	endtask

	// result side
	always @(posedge clk) begin
		tcl_pkg::res_t got, want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = mk(tcl_pkg::event_t'(event_res), granted_road, passed_id,
					passed_urgent, remaining, last);
				if (expected_words.size() == 0) begin
					errors++;
					if (mismatches++ < 10) $display("unexpected word %p", got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						if (mismatches++ < 10)
							$display("mismatch: exp %p got %p", want, got);
					end
				end
			end
			pop <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send(tcl_pkg::cmd_t c, bit quiet);
		if (!quiet)
			while ($urandom_range(99) < 6) begin
				push <= 0;
				@(posedge clk);
			end
		push <= 1;
		kind <= c.kind;
		road <= c.road;
		vehicle_id <= c.vehicle_id;
		urgent <= c.urgent;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_word(c);
	endtask

	task automatic drain;
		push <= 0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_passes(int v);
		cfg_we <= 1;
		cfg_data <= tcl_pkg::PASS_W'(v);
		@(posedge clk);
		cfg_we <= 0;
		green_passes = v;
		@(posedge clk);
	endtask

	function automatic tcl_pkg::cmd_t cmd(logic k, int rd, int id, logic u);
		tcl_pkg::cmd_t c;
		c.kind = k;
		c.road = tcl_pkg::ROAD_W'(rd);
		c.vehicle_id = tcl_pkg::ID_W'(id);
		c.urgent = u;
		return c;
	endfunction

	tcl_pkg::cmd_t plan[$];
	tcl_pkg::res_t given[$];

	initial begin
		tcl_pkg::cmd_t c;
		int p, r;
		green_passes = tcl_pkg::PASS_RST;
		quiet_rx = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table; typed expectations checked against the predictor
		plan = '{cmd(KIND_TICK, 0, 0, 0), cmd(KIND_ARRIVE, 7, 1023, 1),
			cmd(KIND_ARRIVE, 5, 0, 0), cmd(KIND_ARRIVE, 4, 1023, 0),
			cmd(KIND_ARRIVE, 4, 0, 0), cmd(KIND_ARRIVE, 2, 5, 0),
			cmd(KIND_ARRIVE, 2, 6, 1), cmd(KIND_ARRIVE, 2, 7, 1),
			cmd(KIND_TICK, 0, 0, 0), cmd(KIND_TICK, 0, 0, 0),
			cmd(KIND_TICK, 0, 0, 0), cmd(KIND_TICK, 0, 0, 0)};
		given = '{mk(tcl_pkg::EV_EMPTY, 0, 0, 0, 0, 1), mk(tcl_pkg::EV_REJECT, 7, 0, 0, 0, 1),
			mk(tcl_pkg::EV_REJECT, 5, 0, 0, 0, 1), mk(tcl_pkg::EV_ACCEPT, 4, 0, 0, 1, 1)};
		foreach (plan[i]) begin
			if (i < given.size()) begin
				send(plan[i], 0);
				if (expected_words[$] !== given[i]) begin
					errors++;
					$display("table row %0d disagrees with predictor", i);
				end
			end else
				send(plan[i], 0);
		end
		drain();

		// fill road 1 to full with a burst, then reject, then ticks at passes 0 and 15
		quiet_rx = 1;
		for (int i = 0; i < NDEPTH + 1; i++)
			send(cmd(KIND_ARRIVE, 1, $urandom_range(1023), i % 9 == 0), 1);
		drain();
		set_passes(0);
		send(cmd(KIND_TICK, 0, 0, 0), 1);
		drain();
		set_passes(15);
		for (int i = 0; i < 4; i++) send(cmd(KIND_TICK, 0, 0, 0), 1);
		drain();
		quiet_rx = 0;
		for (int i = 0; i < 6; i++) send(cmd(KIND_TICK, 0, 0, 0), 0);
		drain();

		// random traffic in phases of differing green length
		for (int ph = 0; ph < 5; ph++) begin
			p = ph == 0 ? 1 : (ph == 1 ? 8 : $urandom_range(15));
			set_passes(p);
			quiet_rx = (ph == 2);
			for (int i = 0; i < 12; i++) begin
				r = $urandom_range(99);
				if (r < 55)
					c = cmd(KIND_ARRIVE, $urandom_range(4), $urandom, $urandom_range(99) < 25);
				else if (r < 62)
					c = cmd(KIND_ARRIVE, $urandom_range(7), $urandom, $urandom_range(1));
				else
					c = cmd(KIND_TICK, $urandom_range(7), $urandom, $urandom_range(1));
				send(c, ph == 2);
			end
			drain();
		end
		// empty everything out
		set_passes(8);
		for (int i = 0; i < 8; i++) send(cmd(KIND_TICK, 0, 0, 0), 0);
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
